[hw/rtl/gbfp_pkg.sv]
// gbfp_pkg: shared types and constants of the binary frame parser
package gbfp_pkg;

	localparam int POS_W  = 17;
	localparam int LEN_W  = 16;
	localparam int CNT_W  = 32;
	localparam int BYTE_W = 8;
	localparam int STAT_W = 2;

	localparam int IN_DEPTH = 4;

	localparam logic [BYTE_W-1:0] SYNC_FIRST  = 8'hB5;
	localparam logic [BYTE_W-1:0] SYNC_SECOND = 8'h62;

	localparam logic [POS_W-1:0] MAX_FRAME_RESET = 17'd512;

	localparam logic [STAT_W-1:0] ST_INCOMPLETE = 2'd0;
	localparam logic [STAT_W-1:0] ST_OK         = 2'd1;
	localparam logic [STAT_W-1:0] ST_BAD_SUM    = 2'd2;
	localparam logic [STAT_W-1:0] ST_OVERFLOW   = 2'd3;

	// a received byte with its sync-pattern match flags
	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic              sync_first_hit;
		logic              sync_second_hit;
	} cls_t;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [BYTE_W-1:0] frame_byte;
		logic [POS_W-1:0]  byte_pos;
		logic              byte_stored;
		logic [BYTE_W-1:0] msg_class;
		logic [BYTE_W-1:0] msg_id;
		logic [LEN_W-1:0]  payload_len;
		logic [CNT_W-1:0]  restart_count;
		logic [CNT_W-1:0]  received_count;
		logic [CNT_W-1:0]  error_count;
		logic [CNT_W-1:0]  overflow_count;
	} res_t;

endpackage

[hw/rtl/gnss_binary_frame_parser_top.sv]
// gnss_binary_frame_parser_top: byte-stream frame parser with checksum and counters
//
//   channel   direction  handshake               payload
//   input     in         push / full             rx_byte
//   result    out        pop / empty             status, frame_byte, byte_pos, byte_stored,
//                                                msg_class, msg_id, payload_len, 4 counters
//   config    in         max_frame_bytes_we      max_frame_bytes
//
// one byte per cycle sustained while the consumer keeps popping; a byte's result passes
// through the input queue and then the core's update into the result queue, and can be
// popped once it shows on the result ports
// reset clears all counters and header fields and sets capacity to 512 bytes
// the input queue holds IN_DEPTH bytes and the result queue two results, so a stalled
// consumer backs up through the core to full after IN_DEPTH + 2 bytes
module gnss_binary_frame_parser_top #(
	parameter int IN_DEPTH = gbfp_pkg::IN_DEPTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic [gbfp_pkg::BYTE_W-1:0]   rx_byte,
	input  logic                          max_frame_bytes_we,
	input  logic [gbfp_pkg::POS_W-1:0]    max_frame_bytes,
	output logic                          empty,
	input  logic                          pop,
	output logic [gbfp_pkg::STAT_W-1:0]   status,
	output logic [gbfp_pkg::BYTE_W-1:0]   frame_byte,
	output logic [gbfp_pkg::POS_W-1:0]    byte_pos,
	output logic                          byte_stored,
	output logic [gbfp_pkg::BYTE_W-1:0]   msg_class,
	output logic [gbfp_pkg::BYTE_W-1:0]   msg_id,
	output logic [gbfp_pkg::LEN_W-1:0]    payload_len,
	output logic [gbfp_pkg::CNT_W-1:0]    restart_count,
	output logic [gbfp_pkg::CNT_W-1:0]    received_count,
	output logic [gbfp_pkg::CNT_W-1:0]    error_count,
	output logic [gbfp_pkg::CNT_W-1:0]    overflow_count
);

	gbfp_pkg::cls_t item;
	logic           item_valid;
	logic           item_take;
	logic           res_full;
	logic           res_push;
	gbfp_pkg::res_t res;
	gbfp_pkg::res_t head;

	gbfp_front #(
		.DEPTH (IN_DEPTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.rx_byte    (rx_byte),
		.full       (full),
		.item       (item),
		.item_valid (item_valid),
		.item_take  (item_take)
	);

	gbfp_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (max_frame_bytes_we),
		.cfg_wdata  (max_frame_bytes),
		.item       (item),
		.item_valid (item_valid),
		.item_take  (item_take),
		.res_full   (res_full),
		.res_push   (res_push),
		.res        (res)
	);

	gbfp_res_queue u_res_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.din    (res),
		.full   (res_full),
		.pop    (pop),
		.empty  (empty),
		.dout   (head)
	);

	assign status         = head.status;
	assign frame_byte     = head.frame_byte;
	assign byte_pos       = head.byte_pos;
	assign byte_stored    = head.byte_stored;
	assign msg_class      = head.msg_class;
	assign msg_id         = head.msg_id;
	assign payload_len    = head.payload_len;
	assign restart_count  = head.restart_count;
	assign received_count = head.received_count;
	assign error_count    = head.error_count;
	assign overflow_count = head.overflow_count;

endmodule

[hw/rtl/gbfp_front.sv]
// gbfp_front: input byte queue that tags each byte with its sync matches
module gbfp_front #(
	parameter int DEPTH = gbfp_pkg::IN_DEPTH
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	input  logic [gbfp_pkg::BYTE_W-1:0]     rx_byte,
	output logic                            full,
	output gbfp_pkg::cls_t                  item,
	output logic                            item_valid,
	input  logic                            item_take
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CW    = $clog2(DEPTH + 1);

	gbfp_pkg::cls_t   mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CW-1:0]    cnt_q;
	logic             do_push;
	logic             do_pop;
	gbfp_pkg::cls_t   cls_in;

	assign full       = (cnt_q == CW'(DEPTH));
	assign item_valid = (cnt_q != '0);
	assign item       = mem_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = item_take && item_valid;

	always_comb begin
		cls_in.data            = rx_byte;
		cls_in.sync_first_hit  = (rx_byte == gbfp_pkg::SYNC_FIRST);
		cls_in.sync_second_hit = (rx_byte == gbfp_pkg::SYNC_SECOND);
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= cls_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

[hw/rtl/gbfp_core.sv]
// gbfp_core: frame tracking, fletcher sums, header capture and counters
module gbfp_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [gbfp_pkg::POS_W-1:0]    cfg_wdata,
	input  gbfp_pkg::cls_t                item,
	input  logic                          item_valid,
	output logic                          item_take,
	input  logic                          res_full,
	output logic                          res_push,
	output gbfp_pkg::res_t                res
);

	localparam int PW = gbfp_pkg::POS_W;
	localparam int BW = gbfp_pkg::BYTE_W;
	localparam int LW = gbfp_pkg::LEN_W;
	localparam int CW = gbfp_pkg::CNT_W;

	logic [PW-1:0] max_q;
	logic [PW-1:0] pos_q, pos_n;
	logic [PW-1:0] check_pos_q, check_pos_n;
	logic [BW-1:0] sum_a_q, sum_a_n;
	logic [BW-1:0] sum_b_q, sum_b_n;
	logic [BW-1:0] ck_a_q, ck_a_n;
	logic [BW-1:0] class_q, class_n;
	logic [BW-1:0] id_q, id_n;
	logic [LW-1:0] len_q, len_n;
	logic [CW-1:0] restarts_q, restarts_n;
	logic [CW-1:0] received_q, received_n;
	logic [CW-1:0] errors_q, errors_n;
	logic [CW-1:0] overflows_q, overflows_n;
	logic [BW-1:0] c;
	logic [BW-1:0] acc_a;
	logic          in_frame;
	logic [gbfp_pkg::STAT_W-1:0] status;
	logic          fire;

	assign fire      = item_valid && !res_full;
	assign item_take = fire;
	assign res_push  = fire;
	assign c         = item.data;
	assign acc_a     = sum_a_q + c;

	always_comb begin
		pos_n       = pos_q + 1'b1;
		check_pos_n = check_pos_q;
		sum_a_n     = sum_a_q;
		sum_b_n     = sum_b_q;
		ck_a_n      = ck_a_q;
		class_n     = class_q;
		id_n        = id_q;
		len_n       = len_q;
		restarts_n  = restarts_q;
		received_n  = received_q;
		errors_n    = errors_q;
		overflows_n = overflows_q;
		in_frame    = 1'b1;
		status      = gbfp_pkg::ST_INCOMPLETE;
		priority if (pos_q == PW'(0)) begin
			if (!item.sync_first_hit) begin
				restarts_n = restarts_q + 1'b1;
				in_frame   = 1'b0;
				pos_n      = '0;
			end else begin
				sum_a_n = '0;
				sum_b_n = '0;
			end
		end else if (pos_q == PW'(1)) begin
			if (!item.sync_second_hit) begin
				restarts_n = restarts_q + 1'b1;
				in_frame   = 1'b0;
				pos_n      = '0;
			end
		end else if (pos_q < PW'(6)) begin
			sum_a_n = acc_a;
			sum_b_n = sum_b_q + acc_a;
			unique case (pos_q[2:0])
				3'd2: class_n = c;
				3'd3: id_n    = c;
				3'd4: len_n   = {8'd0, c};
				default: begin
					// high length byte: the frame end is now known
					len_n       = {c, len_q[7:0]};
					check_pos_n = PW'(6) + PW'({c, len_q[7:0]});
				end
			endcase
		end else begin
			priority if (pos_q < check_pos_q) begin
				sum_a_n = acc_a;
				sum_b_n = sum_b_q + acc_a;
			end else if (pos_q == check_pos_q) begin
				ck_a_n = c;
			end else begin
				received_n = received_q + 1'b1;
				pos_n      = '0;
				if (({1'b0, check_pos_q} + 18'd2) > {1'b0, max_q}) begin
					overflows_n = overflows_q + 1'b1;
					status      = gbfp_pkg::ST_OVERFLOW;
				end else if (sum_a_q == ck_a_q && sum_b_q == c) begin
					status = gbfp_pkg::ST_OK;
				end else begin
					errors_n = errors_q + 1'b1;
					status   = gbfp_pkg::ST_BAD_SUM;
				end
			end
		end
	end

	always_comb begin
		res.status         = status;
		res.frame_byte     = c;
		res.byte_pos       = pos_q;
		res.byte_stored    = in_frame && (pos_q < max_q);
		res.msg_class      = class_n;
		res.msg_id         = id_n;
		res.payload_len    = len_n;
		res.restart_count  = restarts_n;
		res.received_count = received_n;
		res.error_count    = errors_n;
		res.overflow_count = overflows_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q       <= gbfp_pkg::MAX_FRAME_RESET;
			pos_q       <= '0;
			check_pos_q <= '0;
			sum_a_q     <= '0;
			sum_b_q     <= '0;
			ck_a_q      <= '0;
			class_q     <= '0;
			id_q        <= '0;
			len_q       <= '0;
			restarts_q  <= '0;
			received_q  <= '0;
			errors_q    <= '0;
			overflows_q <= '0;
		end else begin
			if (cfg_we) begin
				max_q <= cfg_wdata;
			end
			if (fire) begin
				pos_q       <= pos_n;
				check_pos_q <= check_pos_n;
				sum_a_q     <= sum_a_n;
				sum_b_q     <= sum_b_n;
				ck_a_q      <= ck_a_n;
				class_q     <= class_n;
				id_q        <= id_n;
				len_q       <= len_n;
				restarts_q  <= restarts_n;
				received_q  <= received_n;
				errors_q    <= errors_n;
				overflows_q <= overflows_n;
			end
		end
	end

endmodule

[hw/rtl/gbfp_res_queue.sv]
// gbfp_res_queue: two-entry result queue in front of the output ports
module gbfp_res_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  gbfp_pkg::res_t din,
	output logic           full,
	input  logic           pop,
	output logic           empty,
	output gbfp_pkg::res_t dout
);

	gbfp_pkg::res_t mem_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     cnt_q;
	logic           do_push;
	logic           do_pop;

	assign full    = (cnt_q == 2'd2);
	assign empty   = (cnt_q == 2'd0);
	assign dout    = mem_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

[hw/rtl/gbfp_checker.sv]
// gbfp_checker: port-level assertions for the frame parser, bound to the top level
module gbfp_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          push,
	input logic                          full,
	input logic [gbfp_pkg::BYTE_W-1:0]   rx_byte,
	input logic                          max_frame_bytes_we,
	input logic [gbfp_pkg::POS_W-1:0]    max_frame_bytes,
	input logic                          empty,
	input logic                          pop,
	input logic [gbfp_pkg::STAT_W-1:0]   status,
	input logic [gbfp_pkg::BYTE_W-1:0]   frame_byte,
	input logic [gbfp_pkg::POS_W-1:0]    byte_pos,
	input logic                          byte_stored,
	input logic [gbfp_pkg::BYTE_W-1:0]   msg_class,
	input logic [gbfp_pkg::BYTE_W-1:0]   msg_id,
	input logic [gbfp_pkg::LEN_W-1:0]    payload_len,
	input logic [gbfp_pkg::CNT_W-1:0]    restart_count,
	input logic [gbfp_pkg::CNT_W-1:0]    received_count,
	input logic [gbfp_pkg::CNT_W-1:0]    error_count,
	input logic [gbfp_pkg::CNT_W-1:0]    overflow_count
);

	// a frame end can only fall on the last byte of an eight-byte frame or later
	a_end_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && status != gbfp_pkg::ST_INCOMPLETE) |-> (byte_pos >= 17'd7))
		else $error("frame end reported before position 7");

	// back-to-back results: the frame counter moves by at most one per byte
	a_recv_step: assert property (@(posedge clk) disable iff (!arst_n)
		($past(pop && !empty) && !empty) |->
		((received_count - $past(received_count)) == 32'd0 ||
		 (received_count - $past(received_count)) == 32'd1))
		else $error("received counter jumped between consecutive results");

	// back-to-back results: restarts move by at most one per byte
	a_restart_step: assert property (@(posedge clk) disable iff (!arst_n)
		($past(pop && !empty) && !empty) |->
		((restart_count - $past(restart_count)) == 32'd0 ||
		 (restart_count - $past(restart_count)) == 32'd1))
		else $error("restart counter jumped between consecutive results");

	// a waiting result holds until its transfer
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(frame_byte) && $stable(byte_pos)))
		else $error("waiting result changed before transfer");

endmodule

bind gnss_binary_frame_parser_top gbfp_checker u_gbfp_checker (.*);

[bench/tb_top.sv]
// tb_top: self-checking bench for the binary frame parser, every byte report checked in order
`timescale 1ns / 1ps

module tb_top;

	localparam int IDLE_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 8;
	localparam int RANDOM_BYTES = 800;
	localparam int PHASES = 6;

	localparam int FAULT_NONE = 0;
	localparam int FAULT_CK_A = 1;
	localparam int FAULT_CK_B = 2;
	localparam int FAULT_TRUNCATE = 3;

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        push = 1'b0;
	logic                        full;
	logic [gbfp_pkg::BYTE_W-1:0] rx_byte = '0;
	logic                        max_frame_bytes_we = 1'b0;
	logic [gbfp_pkg::POS_W-1:0]  max_frame_bytes = gbfp_pkg::MAX_FRAME_RESET;
	logic                        empty;
	logic                        pop = 1'b0;
	logic [gbfp_pkg::STAT_W-1:0] status;
	logic [gbfp_pkg::BYTE_W-1:0] frame_byte;
	logic [gbfp_pkg::POS_W-1:0]  byte_pos;
	logic                        byte_stored;
	logic [gbfp_pkg::BYTE_W-1:0] msg_class;
	logic [gbfp_pkg::BYTE_W-1:0] msg_id;
	logic [gbfp_pkg::LEN_W-1:0]  payload_len;
	logic [gbfp_pkg::CNT_W-1:0]  restart_count;
	logic [gbfp_pkg::CNT_W-1:0]  received_count;
	logic [gbfp_pkg::CNT_W-1:0]  error_count;
	logic [gbfp_pkg::CNT_W-1:0]  overflow_count;

	gnss_binary_frame_parser_top dut (
		.clk                (clk),
		.arst_n             (arst_n),
		.push               (push),
		.full               (full),
		.rx_byte            (rx_byte),
		.max_frame_bytes_we (max_frame_bytes_we),
		.max_frame_bytes    (max_frame_bytes),
		.empty              (empty),
		.pop                (pop),
		.status             (status),
		.frame_byte         (frame_byte),
		.byte_pos           (byte_pos),
		.byte_stored        (byte_stored),
		.msg_class          (msg_class),
		.msg_id             (msg_id),
		.payload_len        (payload_len),
		.restart_count      (restart_count),
		.received_count     (received_count),
		.error_count        (error_count),
		.overflow_count     (overflow_count)
	);

	always #1 clk = ~clk;

	// parser state as the bench tracks it
	logic [gbfp_pkg::POS_W-1:0]  capacity = gbfp_pkg::MAX_FRAME_RESET;
	logic [gbfp_pkg::POS_W-1:0]  frame_pos = '0;
	logic [gbfp_pkg::BYTE_W-1:0] fletcher_a = '0;
	logic [gbfp_pkg::BYTE_W-1:0] fletcher_b = '0;
	logic [gbfp_pkg::BYTE_W-1:0] held_ck_a = '0;
	logic [gbfp_pkg::BYTE_W-1:0] hdr_class = '0;
	logic [gbfp_pkg::BYTE_W-1:0] hdr_id = '0;
	logic [gbfp_pkg::LEN_W-1:0]  hdr_len = '0;
	logic [gbfp_pkg::CNT_W-1:0]  n_restarts = '0;
	logic [gbfp_pkg::CNT_W-1:0]  n_frames = '0;
	logic [gbfp_pkg::CNT_W-1:0]  n_bad_sums = '0;
	logic [gbfp_pkg::CNT_W-1:0]  n_overflows = '0;

	gbfp_pkg::res_t byte_reports[$];
	gbfp_pkg::res_t oldest_report;

	int mismatches = 0;
	int bytes_sent = 0;
	int frames_sent = 0;
	int reports_checked = 0;
	int seen_ok = 0;
	int seen_bad_sum = 0;
	int seen_overflow = 0;
	int idle_cycles = 0;

	// sender and receiver idling controls
	int unsigned gap_max = 3;
	int unsigned burst_left = 0;
	logic [15:0] pop_mask = 16'hFFFF;
	logic        long_stalls = 1'b0;
	logic [3:0]  pop_phase = '0;
	int unsigned stall_left = 0;

	task automatic track_frame_byte(input logic [gbfp_pkg::BYTE_W-1:0] b);
		gbfp_pkg::res_t r;
		logic [gbfp_pkg::POS_W-1:0] nxt;
		logic [gbfp_pkg::POS_W-1:0] ck_pos;
		logic framed;
		framed = 1'b1;
		r.status = gbfp_pkg::ST_INCOMPLETE;
		nxt = frame_pos + 1'b1;
		if (frame_pos == 0) begin
			if (b != gbfp_pkg::SYNC_FIRST) begin
				n_restarts++;
				framed = 1'b0;
				nxt = '0;
			end else begin
				fletcher_a = '0;
				fletcher_b = '0;
			end
		end else if (frame_pos == 1) begin
			if (b != gbfp_pkg::SYNC_SECOND) begin
				n_restarts++;
				framed = 1'b0;
				nxt = '0;
			end
		end else if (frame_pos < 6) begin
			case (frame_pos)
				2: hdr_class = b;
				3: hdr_id = b;
				4: hdr_len = {8'h00, b};
				default: hdr_len[15:8] = b;
			endcase
			fletcher_a = fletcher_a + b;
			fletcher_b = fletcher_b + fletcher_a;
		end else begin
			ck_pos = gbfp_pkg::POS_W'(6) + gbfp_pkg::POS_W'(hdr_len);
			if (frame_pos < ck_pos) begin
				fletcher_a = fletcher_a + b;
				fletcher_b = fletcher_b + fletcher_a;
			end else if (frame_pos == ck_pos) begin
				held_ck_a = b;
			end else begin
				n_frames++;
				if (({1'b0, ck_pos} + 18'd2) > {1'b0, capacity}) begin
					n_overflows++;
					r.status = gbfp_pkg::ST_OVERFLOW;
				end else if (fletcher_a == held_ck_a && fletcher_b == b) begin
					r.status = gbfp_pkg::ST_OK;
				end else begin
					n_bad_sums++;
					r.status = gbfp_pkg::ST_BAD_SUM;
				end
				nxt = '0;
			end
		end
		r.frame_byte = b;
		r.byte_pos = frame_pos;
		r.byte_stored = framed && (frame_pos < capacity);
		r.msg_class = hdr_class;
		r.msg_id = hdr_id;
		r.payload_len = hdr_len;
		r.restart_count = n_restarts;
		r.received_count = n_frames;
		r.error_count = n_bad_sums;
		r.overflow_count = n_overflows;
		frame_pos = nxt;
		byte_reports.push_back(r);
	endtask

	task automatic send_byte(input logic [gbfp_pkg::BYTE_W-1:0] b);
		int unsigned gap;
		if (gap_max != 0) begin
			if (burst_left == 0) begin
				gap = $urandom_range(1, gap_max);
				push <= 1'b0;
				repeat (gap) @(posedge clk);
				burst_left = $urandom_range(1, 24);
			end
			burst_left--;
		end
		push <= 1'b1;
		rx_byte <= b;
		@(posedge clk);
		while (full) @(posedge clk);
		track_frame_byte(b);
		bytes_sent++;
	endtask

	// header, payload and check bytes; a truncated frame stops inside its payload
	task automatic send_frame(input logic [7:0] cls, input logic [7:0] id,
		input logic [15:0] len, input int fault);
		logic [7:0] ck_a;
		logic [7:0] ck_b;
		logic [7:0] b;
		int unsigned body;
		if (fault == FAULT_TRUNCATE && len == 0)
			len = 16'd1;
		body = (fault == FAULT_TRUNCATE) ? $urandom_range(0, 32'(len) - 1) : 32'(len);
		ck_a = cls;
		ck_b = ck_a;
		ck_a += id;
		ck_b += ck_a;
		ck_a += len[7:0];
		ck_b += ck_a;
		ck_a += len[15:8];
		ck_b += ck_a;
		send_byte(gbfp_pkg::SYNC_FIRST);
		send_byte(gbfp_pkg::SYNC_SECOND);
		send_byte(cls);
		send_byte(id);
		send_byte(len[7:0]);
		send_byte(len[15:8]);
		for (int unsigned i = 0; i < body; i++) begin
			b = 8'($urandom_range(0, 255));
			ck_a += b;
			ck_b += ck_a;
			send_byte(b);
		end
		if (fault != FAULT_TRUNCATE) begin
			if (fault == FAULT_CK_A)
				ck_a ^= 8'd1 << $urandom_range(0, 7);
			if (fault == FAULT_CK_B)
				ck_b ^= 8'd1 << $urandom_range(0, 7);
			send_byte(ck_a);
			send_byte(ck_b);
		end
		frames_sent++;
	endtask

	// capacity may only change with nothing in flight
	task automatic set_capacity(input logic [gbfp_pkg::POS_W-1:0] cap);
		push <= 1'b0;
		while (byte_reports.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		max_frame_bytes_we <= 1'b1;
		max_frame_bytes <= cap;
		capacity = cap;
		@(posedge clk);
		max_frame_bytes_we <= 1'b0;
	endtask

	task automatic test_sync_hunt();
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(gbfp_pkg::SYNC_SECOND);
		send_byte(gbfp_pkg::SYNC_FIRST);
		send_byte(gbfp_pkg::SYNC_FIRST);
		send_byte(gbfp_pkg::SYNC_SECOND);
		send_byte(gbfp_pkg::SYNC_FIRST);
		send_byte(8'h00);
	endtask

	task automatic test_frame_outcomes();
		send_frame(8'hFF, 8'h00, 16'd0, FAULT_NONE);
		send_frame(8'h00, 8'hFF, 16'd1, FAULT_CK_A);
		send_frame(8'h5A, 8'hA5, 16'd2, FAULT_CK_B);
	endtask

	task automatic test_capacity_edges();
		set_capacity(17'd8);
		send_frame(8'h01, 8'h02, 16'd0, FAULT_NONE);
		// overflow wins over a bad checksum
		send_frame(8'h01, 8'h03, 16'd1, FAULT_CK_B);
		set_capacity(17'd9);
		send_frame(8'h01, 8'h04, 16'd1, FAULT_NONE);
		set_capacity(17'd5);
		send_frame(8'h02, 8'h05, 16'd0, FAULT_NONE);
		set_capacity(17'd0);
		send_frame(8'h02, 8'h06, 16'd0, FAULT_NONE);
		set_capacity(17'd65543);
		send_frame(8'h03, 8'h07, 16'd3, FAULT_NONE);
	endtask

	task automatic test_random_traffic();
		int unsigned quota;
		int unsigned pick;
		int unsigned len;
		int fault;
		logic [gbfp_pkg::POS_W-1:0] cap;
		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: cap = 17'd8;
				1: cap = 17'd65543;
				2: cap = 17'($urandom_range(9, 40));
				3: cap = 17'($urandom_range(41, 600));
				4: cap = gbfp_pkg::MAX_FRAME_RESET;
				default: cap = 17'($urandom_range(8, 65543));
			endcase
			set_capacity(cap);
			gap_max = (phase % 3 == 0) ? 0 : $urandom_range(2, 12);
			pop_mask = (phase % 2 == 1) ? 16'hFFFF : (16'($urandom) | 16'h0001);
			long_stalls = (phase % 3 != 1);
			quota = bytes_sent + RANDOM_BYTES / PHASES;
			while (bytes_sent < quota) begin
				pick = $urandom_range(0, 99);
				if (pick < 80) begin
					len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 80)
						: $urandom_range(0, 24);
					pick = $urandom_range(0, 99);
					fault = (pick < 80) ? FAULT_NONE : (pick < 90) ? FAULT_CK_A : FAULT_CK_B;
					send_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
						16'(len), fault);
				end else if (pick < 88) begin
					repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
				end else if (pick < 94) begin
					send_byte(gbfp_pkg::SYNC_FIRST);
					pick = $urandom_range(0, 254);
					send_byte(8'((pick >= gbfp_pkg::SYNC_SECOND) ? pick + 1 : pick));
				end else begin
					send_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
						16'($urandom_range(1, 12)), FAULT_TRUNCATE);
				end
			end
		end
	endtask

	function automatic void check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endfunction

	// receiver: rotating pop pattern with occasional long stalls
	always @(posedge clk) begin
		if (stall_left != 0) begin
			pop <= 1'b0;
			stall_left <= stall_left - 1;
		end else begin
			pop <= pop_mask[pop_phase];
			pop_phase <= pop_phase + 1'b1;
			if (long_stalls && $urandom_range(0, 63) == 0)
				stall_left <= $urandom_range(8, 30);
		end
	end

	always @(posedge clk) begin
		if (arst_n && pop && !empty) begin
			if (byte_reports.size() == 0) begin
				$error("report for byte %0d with no transfer outstanding", frame_byte);
				mismatches++;
			end else begin
				oldest_report = byte_reports.pop_front();
				check_field("status", 32'(oldest_report.status), 32'(status));
				check_field("frame_byte", 32'(oldest_report.frame_byte), 32'(frame_byte));
				check_field("byte_pos", 32'(oldest_report.byte_pos), 32'(byte_pos));
				check_field("byte_stored", 32'(oldest_report.byte_stored), 32'(byte_stored));
				check_field("msg_class", 32'(oldest_report.msg_class), 32'(msg_class));
				check_field("msg_id", 32'(oldest_report.msg_id), 32'(msg_id));
				check_field("payload_len", 32'(oldest_report.payload_len), 32'(payload_len));
				check_field("restart_count", oldest_report.restart_count, restart_count);
				check_field("received_count", oldest_report.received_count, received_count);
				check_field("error_count", oldest_report.error_count, error_count);
				check_field("overflow_count", oldest_report.overflow_count, overflow_count);
				reports_checked++;
				case (oldest_report.status)
					gbfp_pkg::ST_OK: seen_ok++;
					gbfp_pkg::ST_BAD_SUM: seen_bad_sum++;
					gbfp_pkg::ST_OVERFLOW: seen_overflow++;
					default: ;
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("stalled for %0d cycles with %0d reports outstanding",
					idle_cycles, byte_reports.size());
				$display("FAILURE");
				$finish;
			end
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_sync_hunt();
		test_frame_outcomes();
		test_capacity_edges();
		test_random_traffic();
		push <= 1'b0;
		while (byte_reports.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("%0d bytes in %0d frames sent, %0d byte reports checked",
			bytes_sent, frames_sent, reports_checked);
		$display("frame ends: %0d ok, %0d bad checksum, %0d overflow; %0d sync restarts",
			seen_ok, seen_bad_sum, seen_overflow, n_restarts);
		if (mismatches == 0 && byte_reports.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

[gnss_binary_frame_parser_top.f]
hw/rtl/gbfp_pkg.sv
hw/rtl/gbfp_front.sv
hw/rtl/gbfp_core.sv
hw/rtl/gbfp_res_queue.sv
hw/rtl/gnss_binary_frame_parser_top.sv
hw/rtl/gbfp_checker.sv
bench/tb_top.sv
